FILE: sv/gsc_pkg.sv
// ----------------------------------------------------------------------------
// gsc_pkg
// Shared constants, codes and control/status types for the grid slot
// claim and first-fit allocator.
// ----------------------------------------------------------------------------
package gsc_pkg;

  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS    = 16;

  // bit index into a row mask, row index into the map
  localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  localparam int MODE_W = 2;
  localparam int REQ_W  = 16;
  localparam int SIZE_W = 5;
  localparam int IN_W   = 40;  // 34 bits of fields, padded to bytes
  localparam int OUT_W  = 16;  // 12 bits of fields, padded to bytes

  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CLAIM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PLACE = 2'd2;

  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  typedef struct packed {
    logic load;        // capture the accepted word
    logic clear_map;   // drop every row valid bit
    logic scan_start;  // read row 0, arm the row counter
    logic scan_step;   // read next row
    logic commit;      // set the chosen bit in the examined row
    logic place_full;  // record the overflow position
    logic out_load;    // move the result into the output register
  } gsc_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              in_grid;     // claim request lies inside the grid
    logic              claim_free;  // requested bit is clear
    logic              hit;         // examined row has a free column
    logic              scan_end;    // examined row is past the last row
  } gsc_status_t;

endpackage

FILE: sv/grid_slot_claim_and_first_fit.sv
// ----------------------------------------------------------------------------
// grid_slot_claim_and_first_fit
// First-fit slot allocator over an occupancy bitmap: clear, claim a
// requested slot, or place in the first free slot in row-major order.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake               payload
//   s_*      in         s_tvalid / s_tready     mode, request_x, request_y
//   m_*      out        m_tvalid / m_tready     kept, found, slot_x, slot_y
//   cfg_*    in         cfg_we (no wait)        0 grid_columns, 1 grid_rows
//
// A place word examines rows in order until one has a free column; when no
// slot is free, an end check past the last row records the overflow. The
// place scan reads one row mask per cycle from the map memory and runs a
// priority encoder on it.
// Reset (rst, synchronous) drops all row valid bits at once, so the map
// reads empty right away; sizes go back to 16 x 16.
// A result waits in the output register; the next word is accepted while
// it waits, and only the hand-off of the following result stalls on m_tready.
//
module grid_slot_claim_and_first_fit
  import gsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // cfg
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  // input words
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // mode[1:0], request_x[17:2], request_y[33:18]
  // result words
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata    // kept[0], found[1], slot_x[6:2], slot_y[11:7]
);

  gsc_cmd_t    cmd;
  gsc_status_t status;

  logic              kept;
  logic              found;
  logic [SIZE_W-1:0] slot_x;
  logic [SIZE_W-1:0] slot_y;

  gsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  gsc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mode      (s_tdata[1:0]),
    .in_request_x (s_tdata[17:2]),
    .in_request_y (s_tdata[33:18]),
    .cmd          (cmd),
    .status       (status),
    .kept         (kept),
    .found        (found),
    .slot_x       (slot_x),
    .slot_y       (slot_y)
  );

  assign m_tdata = {4'b0000, slot_y, slot_x, found, kept};

  // one word in flight: nothing accepted the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("word accepted while busy");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  // a map write only when the checked slot is free
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (status.hit || status.claim_free))
    else $error("commit without a free slot");

  // kept and found come from different modes
  a_flags_apart: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
    else $error("kept and found both set");

endmodule

FILE: sv/gsc_ctrl.sv
// ----------------------------------------------------------------------------
// gsc_ctrl
// Sequencer for the allocator: accepts a word, steps the datapath through
// the clear, claim or row scan, and hands the result to the output register.
// ----------------------------------------------------------------------------
module gsc_ctrl
  import gsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  gsc_status_t status,
  output gsc_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_CLAIM  = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_valid;

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        case (status.mode)
          MODE_CLEAR: begin
            cmd.clear_map = 1'b1;
            state_next    = S_FINISH;
          end
          MODE_CLAIM: begin
            // row read of request_y is issued this cycle
            state_next = status.in_grid ? S_CLAIM : S_FINISH;
          end
          MODE_PLACE: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN;
          end
          default: state_next = S_FINISH;
        endcase
      end
      S_CLAIM: begin
        cmd.commit = status.claim_free;
        state_next = S_FINISH;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.hit) begin
          cmd.commit = 1'b1;
          state_next = S_FINISH;
        end else if (status.scan_end) begin
          cmd.place_full = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: sv/gsc_datapath.sv
// ----------------------------------------------------------------------------
// gsc_datapath
// Occupancy map memory with row valid bits, size registers, request
// registers, first-free column encoder and the result registers.
// ----------------------------------------------------------------------------
module gsc_datapath
  import gsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [SIZE_W-1:0] cfg_data,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [REQ_W-1:0]  in_request_x,
  input  logic [REQ_W-1:0]  in_request_y,
  input  gsc_cmd_t          cmd,
  output gsc_status_t       status,
  output logic              kept,
  output logic              found,
  output logic [SIZE_W-1:0] slot_x,
  output logic [SIZE_W-1:0] slot_y
);

  logic [SIZE_W-1:0] grid_columns;
  logic [SIZE_W-1:0] grid_rows;
  logic [SIZE_W-1:0] cols;
  logic [SIZE_W-1:0] rows;

  logic [MODE_W-1:0] mode;
  logic [REQ_W-1:0]  request_x;
  logic [REQ_W-1:0]  request_y;

  logic [MAX_COLUMNS-1:0] map_mem [MAX_ROWS];
  logic [MAX_ROWS-1:0]    row_valid;

  logic [SIZE_W-1:0]      rd_row;
  logic [MAX_COLUMNS-1:0] rd_data;
  logic                   rd_valid;
  logic [SIZE_W-1:0]      exam_row;
  logic [SIZE_W-1:0]      scan_row;

  logic [MAX_COLUMNS-1:0] row_bits;
  logic [MAX_COLUMNS-1:0] col_mask;
  logic [MAX_COLUMNS-1:0] free_bits;
  logic [COL_AW-1:0]      first_col;
  logic [COL_AW-1:0]      pick_col;
  logic [MAX_COLUMNS-1:0] wr_data;

  logic              res_kept;
  logic              res_found;
  logic [SIZE_W-1:0] res_x;
  logic [SIZE_W-1:0] res_y;

  // sizes above the map clamp to the map
  assign cols = (int'(grid_columns) > MAX_COLUMNS) ? SIZE_W'(MAX_COLUMNS) : grid_columns;
  assign rows = (int'(grid_rows) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : grid_rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= SIZE_RESET;
      grid_rows    <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_COLUMNS) begin
        grid_columns <= cfg_data;
      end else begin
        grid_rows <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode      <= in_mode;
      request_x <= in_request_x;
      request_y <= in_request_y;
    end
  end

  // read address: scan counter during place, request row otherwise
  always_comb begin
    if (cmd.scan_start) begin
      rd_row = '0;
    end else if (cmd.scan_step) begin
      rd_row = scan_row;
    end else begin
      rd_row = request_y[SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rd_data  <= map_mem[rd_row[ROW_AW-1:0]];
    rd_valid <= row_valid[rd_row[ROW_AW-1:0]];
    exam_row <= rd_row;
    if (cmd.scan_start) begin
      scan_row <= SIZE_W'(1);
    end else if (cmd.scan_step) begin
      scan_row <= scan_row + SIZE_W'(1);
    end
  end

  // an unwritten row reads as empty
  assign row_bits = rd_valid ? rd_data : '0;

  always_comb begin
    for (int c = 0; c < MAX_COLUMNS; c++) begin
      col_mask[c] = (c < int'(cols));
    end
  end

  assign free_bits = ~row_bits & col_mask;

  always_comb begin
    first_col = '0;
    for (int c = MAX_COLUMNS - 1; c >= 0; c--) begin
      if (free_bits[c]) begin
        first_col = COL_AW'(c);
      end
    end
  end

  assign pick_col = (mode == MODE_CLAIM) ? request_x[COL_AW-1:0] : first_col;
  assign wr_data  = row_bits | (MAX_COLUMNS'(1) << pick_col);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      map_mem[exam_row[ROW_AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_map) begin
      row_valid <= '0;
    end else if (cmd.commit) begin
      row_valid[exam_row[ROW_AW-1:0]] <= 1'b1;
    end
  end

  assign status.mode       = mode;
  assign status.in_grid    = !request_x[REQ_W-1] && !request_y[REQ_W-1] &&
                             (request_x < REQ_W'(cols)) && (request_y < REQ_W'(rows));
  assign status.claim_free = !row_bits[request_x[COL_AW-1:0]];
  assign status.scan_end   = (exam_row >= rows);
  assign status.hit        = !status.scan_end && (|free_bits);

  // result staging: zero on load, filled by commit or overflow
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_kept  <= 1'b0;
      res_found <= 1'b0;
      res_x     <= '0;
      res_y     <= '0;
    end else if (cmd.commit) begin
      if (mode == MODE_CLAIM) begin
        res_kept <= 1'b1;
      end else begin
        res_found <= 1'b1;
        res_x     <= SIZE_W'(first_col);
        res_y     <= exam_row;
      end
    end else if (cmd.place_full) begin
      res_x <= cols;
      res_y <= rows;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      kept   <= res_kept;
      found  <= res_found;
      slot_x <= res_x;
      slot_y <= res_y;
    end
  end

endmodule
